// ===== hw/rtl/b64d_pkg.sv =====
// Shared types and constants for the base64 character stream decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package b64d_pkg;

    localparam int CHAR_W  = 8;
    localparam int SEXT_W  = 6;
    localparam int COUNT_W = 16;
    localparam int PHASE_W = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CHAR_W-1:0] CHR_UC_A  = 8'h41;  // 'A'
    localparam logic [CHAR_W-1:0] CHR_UC_Z  = 8'h5A;  // 'Z'
    localparam logic [CHAR_W-1:0] CHR_LC_A  = 8'h61;  // 'a'
    localparam logic [CHAR_W-1:0] CHR_LC_Z  = 8'h7A;  // 'z'
    localparam logic [CHAR_W-1:0] CHR_D0    = 8'h30;  // '0'
    localparam logic [CHAR_W-1:0] CHR_D9    = 8'h39;  // '9'
    localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;  // '+'
    localparam logic [CHAR_W-1:0] CHR_SLASH = 8'h2F;  // '/'
    localparam logic [CHAR_W-1:0] CHR_PAD   = 8'h3D;  // '='

    localparam logic [CHAR_W-1:0] LC_OFFSET  = 8'd26;
    localparam logic [CHAR_W-1:0] DIG_OFFSET = 8'd52;
    localparam logic [SEXT_W-1:0] SEXT_PLUS  = 6'd62;
    localparam logic [SEXT_W-1:0] SEXT_SLASH = 6'd63;

    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_ALPHA = 2'd1,
        CLS_PAD   = 2'd2,
        CLS_BAD   = 2'd3
    } char_class_t;

    typedef struct packed {
        char_class_t       cls;
        logic [SEXT_W-1:0] sextet;
    } char_info_t;

    typedef struct packed {
        logic [COUNT_W-1:0] byte_count;
        logic               failed;
        logic               done_res;
        logic               byte_valid;
        logic [CHAR_W-1:0]  data_byte;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/base64_char_stream_decoder_core.sv =====
// Top level of the base64 character stream decoder: input register,
// classifier, pair logic and result register. Uses b64d_pkg,
// b64d_classify and b64d_pair.
//
//   channel | direction | tdata                   | tuser               | tlast
//   --------+-----------+-------------------------+---------------------+------------
//   s_axis  | in        | char_code[7:0]          | -                   | end_of_text
//   m_axis  | out       | data_byte[7:0],         | byte_valid[0],      | done_res
//           |           | byte_count[23:8]        | failed[1]           |
//
// One character per cycle sustained while m_axis is ready; each transfer in
// yields exactly one transfer out, via the input register, then the result
// register. The critical path is the alphabet range compares feeding the
// 16-bit count increment. Reset (rst_n low, asynchronous) empties both
// stages and returns the pair state to the start of a string. A stall on
// m_axis holds the result register; the input register still takes one
// more character, and s_axis_tready drops only while both stages are full.
`default_nettype none

module base64_char_stream_decoder_core
    import b64d_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [CHAR_W-1:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic               s_axis_tlast,   // end_of_text

    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [23:0]             m_axis_tdata,   // [7:0] data_byte, [23:8] byte_count
    output logic [1:0]              m_axis_tuser,   // [0] byte_valid, [1] failed
    output logic                    m_axis_tlast    // done_res
);

    // input stage
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;

    // result stage
    logic              out_valid_reg;
    result_t           out_res_reg;

    logic              advance;
    logic              in_take;
    char_info_t        info;
    result_t           res;

    // character moves from input register to result register when the
    // result register is empty or its transfer completes this cycle
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    b64d_classify u_classify (
        .char_code (in_char_reg),
        .info      (info)
    );

    b64d_pair u_pair (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .info    (info),
        .last    (in_last_reg),
        .result  (res)
    );

    // stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance)
        begin
            out_res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.byte_count, out_res_reg.data_byte};
    assign m_axis_tuser  = {out_res_reg.failed, out_res_reg.byte_valid};
    assign m_axis_tlast  = out_res_reg.done_res;

`ifndef SYNTHESIS
    a_in_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_char_reg))
        else $error("pending character lost");

    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_axis_tready |=> out_valid_reg)
        else $error("pending result lost");

    a_byte_not_failed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> !m_axis_tuser[1])
        else $error("byte flagged valid on a failed string");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_classify.sv =====
// Character classifier: maps an ASCII code to its base64 class and sextet.
// Depends on b64d_pkg.
`default_nettype none

module b64d_classify
    import b64d_pkg::*;
(
    input  wire logic [CHAR_W-1:0] char_code,
    output char_info_t             info
);

    logic [CHAR_W-1:0] diff_uc;
    logic [CHAR_W-1:0] diff_lc;
    logic [CHAR_W-1:0] diff_dig;

    assign diff_uc  = char_code - CHR_UC_A;
    assign diff_lc  = char_code - CHR_LC_A + LC_OFFSET;
    assign diff_dig = char_code - CHR_D0 + DIG_OFFSET;

    // parallel range compares; non-alphabet codes carry sextet zero
    always_comb
    begin
        info.cls    = CLS_BAD;
        info.sextet = '0;
        if (char_code >= CHR_UC_A && char_code <= CHR_UC_Z)
        begin
            info.cls    = CLS_ALPHA;
            info.sextet = diff_uc[SEXT_W-1:0];
        end
        else if (char_code >= CHR_LC_A && char_code <= CHR_LC_Z)
        begin
            info.cls    = CLS_ALPHA;
            info.sextet = diff_lc[SEXT_W-1:0];
        end
        else if (char_code >= CHR_D0 && char_code <= CHR_D9)
        begin
            info.cls    = CLS_ALPHA;
            info.sextet = diff_dig[SEXT_W-1:0];
        end
        else if (char_code == CHR_PLUS)
        begin
            info.cls    = CLS_ALPHA;
            info.sextet = SEXT_PLUS;
        end
        else if (char_code == CHR_SLASH)
        begin
            info.cls    = CLS_ALPHA;
            info.sextet = SEXT_SLASH;
        end
        else if (char_code == CHR_PAD)
        begin
            info.cls    = CLS_PAD;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/b64d_pair.sv =====
// Pair state and byte assembly: holds the previous sextet, phase, sticky
// error and byte count, and forms one result per character. Uses b64d_pkg.
`default_nettype none

module b64d_pair
    import b64d_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       advance,   // current character moves to the result stage
    input  wire char_info_t info,
    input  wire logic       last,
    output result_t         result
);

    logic [SEXT_W-1:0]  prev_sextet_reg, prev_sextet_next;
    char_class_t        prev_class_reg,  prev_class_next;
    logic [PHASE_W-1:0] phase_reg,       phase_next;
    logic               error_reg,       error_next;
    logic [COUNT_W-1:0] count_reg,       count_next;

    logic               check_pair;
    logic [CHAR_W-1:0]  byte_val;
    logic               byte_ok;
    logic [SEXT_W-1:0]  a;
    logic [SEXT_W-1:0]  b;

    assign a = prev_sextet_reg;
    assign b = info.sextet;

    // a pair is examined unless an error is set, either side is padding or no character came before
    assign check_pair = !error_reg && prev_class_reg != CLS_NONE
                        && prev_class_reg != CLS_PAD && info.cls != CLS_PAD;

    always_comb
    begin
        byte_val   = '0;
        byte_ok    = 1'b0;
        error_next = error_reg;
        count_next = count_reg;
        if (check_pair)
        begin
            if (prev_class_reg == CLS_BAD || info.cls == CLS_BAD)
            begin
                error_next = 1'b1;
            end
            else
            begin
                // first member of the pair sits one position behind phase
                unique case (phase_reg)
                    2'd1:
                    begin
                        byte_val = {a, b[5:4]};
                        byte_ok  = 1'b1;
                    end
                    2'd2:
                    begin
                        byte_val = {a[3:0], b[5:2]};
                        byte_ok  = 1'b1;
                    end
                    2'd3:
                    begin
                        byte_val = {a[1:0], b};
                        byte_ok  = 1'b1;
                    end
                    default:
                    begin
                        byte_ok  = 1'b0;
                    end
                endcase
                if (byte_ok && count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
        end
    end

    assign result.data_byte  = byte_val;
    assign result.byte_valid = byte_ok;
    assign result.done_res   = last;
    assign result.failed     = error_next;
    assign result.byte_count = count_next;

    assign prev_sextet_next = last ? '0 : info.sextet;
    assign prev_class_next  = last ? CLS_NONE : info.cls;

    always_comb
    begin
        phase_next = phase_reg + 1'b1;
        if (last)
        begin
            phase_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_sextet_reg <= '0;
            prev_class_reg  <= CLS_NONE;
            phase_reg       <= '0;
            error_reg       <= 1'b0;
            count_reg       <= '0;
        end
        else if (advance)
        begin
            prev_sextet_reg <= prev_sextet_next;
            prev_class_reg  <= prev_class_next;
            phase_reg       <= phase_next;
            error_reg       <= last ? 1'b0 : error_next;
            count_reg       <= last ? '0 : count_next;
        end
    end

`ifndef SYNTHESIS
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> phase_reg == '0 && count_reg == '0 && !error_reg
                            && prev_class_reg == CLS_NONE)
        else $error("string end did not clear pair state");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg && !(advance && last) |=> error_reg)
        else $error("sticky error dropped inside a string");

    a_no_byte_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> !result.byte_valid && result.byte_count == count_reg)
        else $error("byte produced after error");
`endif

endmodule

`default_nettype wire

// ===== tb/base64_char_stream_decoder_core_tb.sv =====
// Self-checking testbench for base64_char_stream_decoder_core: drives character
// strings on s_axis, predicts each decoded result and checks every m_axis transfer.
// Depends on b64d_pkg and the core RTL only.
`timescale 1ns / 1ps

module base64_char_stream_decoder_core_tb;
    import b64d_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int TAIL_CYCLES  = 6;
    localparam int MAX_REPORTS  = 10;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [CHAR_W-1:0]  s_axis_tdata = '0;   // [7:0] char_code
    logic               s_axis_tlast = 1'b0; // end_of_text
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [23:0]        m_axis_tdata;        // [7:0] data_byte, [23:8] byte_count
    logic [1:0]         m_axis_tuser;        // [0] byte_valid, [1] failed
    logic               m_axis_tlast;        // done_res

    // decoder state mirrored by the predictor
    logic [SEXT_W-1:0]  last_sextet;
    char_class_t        last_class;
    logic [PHASE_W-1:0] char_pos;
    logic               decode_error;
    logic [COUNT_W-1:0] decoded_bytes;

    result_t pending_results[$];
    int      mismatch_count = 0;
    int      sender_idle_pct = 0;
    int      receiver_stall_pct = 0;

    base64_char_stream_decoder_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case a handshake hangs
    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("CHECKS FAILED");
        $finish;
    end

    // Map a character to its alphabet class and sextet; sextet is 0 off-alphabet.
    function automatic char_info_t sort_char(input logic [CHAR_W-1:0] code);
        char_info_t        info;
        logic [CHAR_W-1:0] ofs;
        info.cls    = CLS_BAD;
        info.sextet = '0;
        ofs         = '0;
        if (code >= CHR_UC_A && code <= CHR_UC_Z)
        begin
            info.cls = CLS_ALPHA;
            ofs      = code - CHR_UC_A;
        end
        else if (code >= CHR_LC_A && code <= CHR_LC_Z)
        begin
            info.cls = CLS_ALPHA;
            ofs      = code - CHR_LC_A + LC_OFFSET;
        end
        else if (code >= CHR_D0 && code <= CHR_D9)
        begin
            info.cls = CLS_ALPHA;
            ofs      = code - CHR_D0 + DIG_OFFSET;
        end
        else if (code == CHR_PLUS)
        begin
            info.cls = CLS_ALPHA;
            ofs      = CHAR_W'(SEXT_PLUS);
        end
        else if (code == CHR_SLASH)
        begin
            info.cls = CLS_ALPHA;
            ofs      = CHAR_W'(SEXT_SLASH);
        end
        else if (code == CHR_PAD)
            info.cls = CLS_PAD;
        info.sextet = ofs[SEXT_W-1:0];
        return info;
    endfunction

    function automatic void clear_decoder_state();
        last_sextet   = '0;
        last_class    = CLS_NONE;
        char_pos      = '0;
        decode_error  = 1'b0;
        decoded_bytes = '0;
    endfunction

    // Advance the mirrored decoder by one character and return its result.
    function automatic result_t decode_next(input logic [CHAR_W-1:0] code, input logic last);
        char_info_t         cur;
        result_t            res;
        logic [PHASE_W-1:0] pair_pos;
        cur      = sort_char(code);
        res      = '0;
        // position of the pair's first member is one behind the current char
        pair_pos = char_pos - 1'b1;
        if (!decode_error && last_class != CLS_NONE && last_class != CLS_PAD
            && cur.cls != CLS_PAD)
        begin
            if (last_class == CLS_BAD || cur.cls == CLS_BAD)
                decode_error = 1'b1;
            else
            begin
                case (pair_pos)
                    2'd0: res.data_byte = {last_sextet, cur.sextet[5:4]};
                    2'd1: res.data_byte = {last_sextet[3:0], cur.sextet[5:2]};
                    2'd2: res.data_byte = {last_sextet[1:0], cur.sextet};
                    default: res.data_byte = '0;
                endcase
                res.byte_valid = (pair_pos != 2'd3);
                if (res.byte_valid && decoded_bytes != COUNT_MAX)
                    decoded_bytes = decoded_bytes + 1'b1;
            end
        end
        res.done_res   = last;
        res.failed     = decode_error;
        res.byte_count = decoded_bytes;
        if (last)
            clear_decoder_state();
        else
        begin
            last_sextet = cur.sextet;
            last_class  = cur.cls;
            char_pos    = char_pos + 1'b1;
        end
        return res;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_b64_char();
        int idx;
        idx = $urandom_range(63);
        if (idx < 26)
            return CHR_UC_A + CHAR_W'(idx);
        else if (idx < 52)
            return CHR_LC_A + CHAR_W'(idx - 26);
        else if (idx < 62)
            return CHR_D0 + CHAR_W'(idx - 52);
        else if (idx == 62)
            return CHR_PLUS;
        return CHR_SLASH;
    endfunction

    task automatic log_mismatch(input string what, input result_t want, input result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: %s: expected byte=%02h valid=%b done=%b failed=%b count=%0d,",
                      " got byte=%02h valid=%b done=%b failed=%b count=%0d"},
                     $realtime, what,
                     want.data_byte, want.byte_valid, want.done_res, want.failed,
                     want.byte_count,
                     got.data_byte, got.byte_valid, got.done_res, got.failed,
                     got.byte_count);
    endtask

    // Receiver: random backpressure on m_axis.
    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // Result checker: every m_axis transfer against the oldest prediction.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.data_byte  = m_axis_tdata[7:0];
            got.byte_count = m_axis_tdata[23:8];
            got.byte_valid = m_axis_tuser[0];
            got.failed     = m_axis_tuser[1];
            got.done_res   = m_axis_tlast;
            if (pending_results.size() == 0)
                log_mismatch("result with none expected", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got.data_byte !== want.data_byte || got.byte_valid !== want.byte_valid
                    || got.done_res !== want.done_res || got.failed !== want.failed
                    || got.byte_count !== want.byte_count)
                    log_mismatch("result mismatch", want, got);
            end
        end
    end

    // Send one character; the prediction is queued at the accepting edge.
    task automatic send_char(input logic [CHAR_W-1:0] code, input logic last);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= code;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(decode_next(code, last));
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], i == text.len() - 1);
    endtask

    task automatic wait_results_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_idling(input int idle_pct, input int stall_pct);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
    endtask

    task automatic test_directed_cases();
        send_text("TWFu");      // plain quartet: "Man"
        send_text("/+9z");      // top sextets and alphabet edges
        send_text("A");         // single character: no pair at all
        send_text("aZ0=");      // trailing pad skips its pair
        send_text("Q=Ab");      // pad mid-string, decoding resumes after it
        // extremes of the code range, codes above 127 are invalid
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(CHR_UC_A, 1'b0);
        send_char(8'h80, 1'b1);
        send_text("Bq!Ak");     // error after one byte, count sticks
    endtask

    // Mostly well-formed strings, some corrupted or cut short, some raw noise.
    task automatic test_random_strings(input int item_goal);
        logic [CHAR_W-1:0] text[$];
        int sent;
        int kind;
        int n_pad;
        int cut;
        int n_len;
        sent = 0;
        while (sent < item_goal)
        begin
            text.delete();
            kind = $urandom_range(99);
            if (kind < 85)
            begin
                n_len = 4 * $urandom_range(1, 6);
                for (int i = 0; i < n_len; i++)
                    text.push_back(pick_b64_char());
                n_pad = $urandom_range(2);
                for (int i = 0; i < n_pad; i++)
                    text[text.size() - 1 - i] = CHR_PAD;
                if (kind >= 70)
                begin
                    if ($urandom_range(1))
                        text[$urandom_range(text.size() - 1)] = CHAR_W'($urandom_range(1, 255));
                    else
                    begin
                        cut = $urandom_range(1, text.size() - 1);
                        while (text.size() > cut)
                            void'(text.pop_back());
                    end
                end
            end
            else
            begin
                n_len = $urandom_range(1, 12);
                for (int i = 0; i < n_len; i++)
                    text.push_back(CHAR_W'($urandom_range(1, 255)));
            end
            for (int i = 0; i < text.size(); i++)
                send_char(text[i], i == text.size() - 1);
            sent += text.size();
        end
    endtask

    initial
    begin
        clear_decoder_state();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        wait_results_drained();     // sender holds off until all results are back

        set_idling(0, 0);
        test_random_strings(430);
        set_idling(64, 0);
        test_random_strings(430);
        set_idling(0, 64);
        test_random_strings(430);
        set_idling(24, 24);
        test_random_strings(430);

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_classify.sv
hw/rtl/b64d_pair.sv
hw/rtl/base64_char_stream_decoder_core.sv
tb/base64_char_stream_decoder_core_tb.sv
